>>> src/pti_pkg.sv
`timescale 1ns / 1ps

package pti_pkg;

  // Coordinate format and derived arithmetic widths.
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int PART_W    = DOT_W + 2;
  localparam int WIDE_W    = 2 * DOT_W;
  localparam int PARAM_W   = FRAC_W + 1;
  localparam int MP_W      = EDGE_W + PARAM_W + 1;
  localparam int ACC_W     = MP_W + 2;
  localparam int DIST_W    = 2 * COORD_W;
  localparam int DSUM_W    = PROD_W + 2;
  localparam int DIV_STEPS = FRAC_W;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [MP_W-1:0]    mprod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [PARAM_W-1:0]        param_t;

  // Source of one edge parameter.
  typedef enum logic [1:0] {
    PSEL_ZERO,
    PSEL_ONE,
    PSEL_QUOT,
    PSEL_COMPL
  } psel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
    logic signed [COORD_W-1:0] vert0_x;
    logic signed [COORD_W-1:0] vert0_y;
    logic signed [COORD_W-1:0] vert0_z;
    logic signed [COORD_W-1:0] vert1_x;
    logic signed [COORD_W-1:0] vert1_y;
    logic signed [COORD_W-1:0] vert1_z;
    logic signed [COORD_W-1:0] vert2_x;
    logic signed [COORD_W-1:0] vert2_y;
    logic signed [COORD_W-1:0] vert2_z;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic                      degenerate;
    logic [PARAM_W-1:0]        edge0_param;
    logic [PARAM_W-1:0]        edge1_param;
    logic signed [COORD_W-1:0] closest_x;
    logic signed [COORD_W-1:0] closest_y;
    logic signed [COORD_W-1:0] closest_z;
    logic [DIST_W-1:0]         distance_sq;
  } out_item_t;

  // Geometry that travels alongside the arithmetic.
  typedef struct packed {
    coord_t [2:0] p;
    coord_t [2:0] v0;
    edge_t  [2:0] e0;
    edge_t  [2:0] e1;
  } geo_t;

  typedef struct packed {
    geo_t  geo;
    psel_t s_sel;
    psel_t t_sel;
    logic  degen;
  } sb_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    sb_t   sb;
    wide_t num0;
    wide_t den0;
    wide_t num1;
    wide_t den1;
  } qitem_t;

  // Partial products of a split wide multiply.
  typedef struct packed {
    logic signed [PART_W-1:0] hh;
    logic signed [PART_W-1:0] hl;
    logic signed [PART_W-1:0] lh;
    logic signed [PART_W-1:0] ll;
  } part_t;

  function automatic part_t mul_split(input dot_t x, input dot_t y);
    logic signed [HALF_W-1:0] xh;
    logic signed [HALF_W-1:0] yh;
    logic signed [HALF_W:0]   xl;
    logic signed [HALF_W:0]   yl;
    part_t r;
    xh = x[DOT_W-1:HALF_W];
    yh = y[DOT_W-1:HALF_W];
    xl = {1'b0, x[HALF_W-1:0]};
    yl = {1'b0, y[HALF_W-1:0]};
    r.hh = xh * yh;
    r.hl = xh * yl;
    r.lh = xl * yh;
    r.ll = xl * yl;
    return r;
  endfunction

  function automatic wide_t mul_join(input part_t pp);
    wide_t hh;
    wide_t hl;
    wide_t lh;
    wide_t ll;
    hh = pp.hh;
    hl = pp.hl;
    lh = pp.lh;
    ll = pp.ll;
    return (hh <<< (2 * HALF_W)) + ((hl + lh) <<< HALF_W) + ll;
  endfunction

endpackage

>>> src/pti_queue.sv
`timescale 1ns / 1ps

module pti_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pti_pkg::qitem_t push_data,
  input  logic            pop,
  output pti_pkg::qitem_t pop_data,
  output logic            full,
  output logic            empty
);

  pti_pkg::qitem_t               mem_r [pti_pkg::QUEUE_DEPTH];
  logic [pti_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [pti_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [pti_pkg::QPTR_W:0]      count_r, count_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_nxt    = push ? wr_r + pti_pkg::QPTR_W'(1) : wr_r;
    rd_nxt    = pop ? rd_r + pti_pkg::QPTR_W'(1) : rd_r;
    count_nxt = count_r + (pti_pkg::QPTR_W+1)'(push) - (pti_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_r];
  assign full     = (count_r == (pti_pkg::QPTR_W+1)'(pti_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);

endmodule

>>> src/pti_front.sv
`timescale 1ns / 1ps

module pti_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pti_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output pti_pkg::qitem_t   push_data
);

  localparam int STAGES = 8;

  typedef struct packed {
    pti_pkg::geo_t               geo;
    pti_pkg::edge_t [2:0]        w;
  } st1_t;

  typedef struct packed {
    pti_pkg::geo_t               geo;
    pti_pkg::prod_t [2:0]        pa;
    pti_pkg::prod_t [2:0]        pb;
    pti_pkg::prod_t [2:0]        pc;
    pti_pkg::prod_t [2:0]        pd;
    pti_pkg::prod_t [2:0]        pe;
  } st2_t;

  typedef struct packed {
    pti_pkg::geo_t geo;
    pti_pkg::dot_t a;
    pti_pkg::dot_t b;
    pti_pkg::dot_t c;
    pti_pkg::dot_t d;
    pti_pkg::dot_t e;
  } st3_t;

  typedef struct packed {
    st3_t           dots;
    pti_pkg::part_t ac;
    pti_pkg::part_t bb;
    pti_pkg::part_t be;
    pti_pkg::part_t cd;
    pti_pkg::part_t bd;
    pti_pkg::part_t ae;
  } st4_t;

  typedef struct packed {
    st3_t           dots;
    pti_pkg::wide_t ac;
    pti_pkg::wide_t bb;
    pti_pkg::wide_t be;
    pti_pkg::wide_t cd;
    pti_pkg::wide_t bd;
    pti_pkg::wide_t ae;
  } st5_t;

  typedef struct packed {
    pti_pkg::geo_t  geo;
    pti_pkg::wide_t det;
    pti_pkg::wide_t sn;
    pti_pkg::wide_t tn;
    pti_pkg::wide_t den;
    pti_pkg::wide_t diff_a;
    pti_pkg::wide_t diff_b;
    pti_pkg::wide_t m1_a;
    pti_pkg::wide_t m1_b;
    pti_pkg::wide_t negd;
    pti_pkg::wide_t nege;
    pti_pkg::wide_t a;
    pti_pkg::wide_t c;
    logic           dneg;
  } st6_t;

  typedef struct packed {
    pti_pkg::geo_t  geo;
    pti_pkg::wide_t det;
    pti_pkg::wide_t sn;
    pti_pkg::wide_t tn;
    pti_pkg::wide_t den;
    pti_pkg::wide_t diff_a;
    pti_pkg::wide_t diff_b;
    pti_pkg::wide_t negd;
    pti_pkg::wide_t nege;
    pti_pkg::wide_t a;
    pti_pkg::wide_t c;
    logic           le;
    logic           sn_neg;
    logic           tn_neg;
    logic           dneg;
    logic           degen;
    logic           diff_a_pos;
    logic           diff_b_pos;
    logic           m1a_le0;
    logic           m1b_le0;
  } st7_t;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic              en;
  st1_t              s1_r, s1_nxt;
  st2_t              s2_r, s2_nxt;
  st3_t              s3_r, s3_nxt;
  st4_t              s4_r, s4_nxt;
  st5_t              s5_r, s5_nxt;
  st6_t              s6_r, s6_nxt;
  st7_t              s7_r, s7_nxt;
  pti_pkg::qitem_t   s8_r, s8_nxt;
  pti_pkg::wide_t    le_sum;

  // The front moves whenever its last stage can drain into the queue.
  assign en        = !vld_r[STAGES-1] || !q_full;
  assign in_ready  = en;
  assign push      = vld_r[STAGES-1] && en;
  assign push_data = s8_r;
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: edge vectors and the vertex-to-query offset.
  always_comb begin
    s1_nxt.geo.p[0]  = in_data.query_x;
    s1_nxt.geo.p[1]  = in_data.query_y;
    s1_nxt.geo.p[2]  = in_data.query_z;
    s1_nxt.geo.v0[0] = in_data.vert0_x;
    s1_nxt.geo.v0[1] = in_data.vert0_y;
    s1_nxt.geo.v0[2] = in_data.vert0_z;
    s1_nxt.geo.e0[0] = pti_pkg::edge_t'(in_data.vert1_x) - pti_pkg::edge_t'(in_data.vert0_x);
    s1_nxt.geo.e0[1] = pti_pkg::edge_t'(in_data.vert1_y) - pti_pkg::edge_t'(in_data.vert0_y);
    s1_nxt.geo.e0[2] = pti_pkg::edge_t'(in_data.vert1_z) - pti_pkg::edge_t'(in_data.vert0_z);
    s1_nxt.geo.e1[0] = pti_pkg::edge_t'(in_data.vert2_x) - pti_pkg::edge_t'(in_data.vert0_x);
    s1_nxt.geo.e1[1] = pti_pkg::edge_t'(in_data.vert2_y) - pti_pkg::edge_t'(in_data.vert0_y);
    s1_nxt.geo.e1[2] = pti_pkg::edge_t'(in_data.vert2_z) - pti_pkg::edge_t'(in_data.vert0_z);
    s1_nxt.w[0]      = pti_pkg::edge_t'(in_data.vert0_x) - pti_pkg::edge_t'(in_data.query_x);
    s1_nxt.w[1]      = pti_pkg::edge_t'(in_data.vert0_y) - pti_pkg::edge_t'(in_data.query_y);
    s1_nxt.w[2]      = pti_pkg::edge_t'(in_data.vert0_z) - pti_pkg::edge_t'(in_data.query_z);
  end

  // Stage 2: the fifteen component products of the dot products.
  always_comb begin
    s2_nxt.geo = s1_r.geo;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.pa[i] = $signed(s1_r.geo.e0[i]) * $signed(s1_r.geo.e0[i]);
      s2_nxt.pb[i] = $signed(s1_r.geo.e0[i]) * $signed(s1_r.geo.e1[i]);
      s2_nxt.pc[i] = $signed(s1_r.geo.e1[i]) * $signed(s1_r.geo.e1[i]);
      s2_nxt.pd[i] = $signed(s1_r.geo.e0[i]) * $signed(s1_r.w[i]);
      s2_nxt.pe[i] = $signed(s1_r.geo.e1[i]) * $signed(s1_r.w[i]);
    end
  end

  // Stage 3: sum the components into a, b, c, d and e.
  always_comb begin
    s3_nxt.geo = s2_r.geo;
    s3_nxt.a = pti_pkg::dot_t'($signed(s2_r.pa[0])) + pti_pkg::dot_t'($signed(s2_r.pa[1]))
             + pti_pkg::dot_t'($signed(s2_r.pa[2]));
    s3_nxt.b = pti_pkg::dot_t'($signed(s2_r.pb[0])) + pti_pkg::dot_t'($signed(s2_r.pb[1]))
             + pti_pkg::dot_t'($signed(s2_r.pb[2]));
    s3_nxt.c = pti_pkg::dot_t'($signed(s2_r.pc[0])) + pti_pkg::dot_t'($signed(s2_r.pc[1]))
             + pti_pkg::dot_t'($signed(s2_r.pc[2]));
    s3_nxt.d = pti_pkg::dot_t'($signed(s2_r.pd[0])) + pti_pkg::dot_t'($signed(s2_r.pd[1]))
             + pti_pkg::dot_t'($signed(s2_r.pd[2]));
    s3_nxt.e = pti_pkg::dot_t'($signed(s2_r.pe[0])) + pti_pkg::dot_t'($signed(s2_r.pe[1]))
             + pti_pkg::dot_t'($signed(s2_r.pe[2]));
  end

  // Stage 4: partial products of the six wide multiplies.
  always_comb begin
    s4_nxt.dots = s3_r;
    s4_nxt.ac   = pti_pkg::mul_split(s3_r.a, s3_r.c);
    s4_nxt.bb   = pti_pkg::mul_split(s3_r.b, s3_r.b);
    s4_nxt.be   = pti_pkg::mul_split(s3_r.b, s3_r.e);
    s4_nxt.cd   = pti_pkg::mul_split(s3_r.c, s3_r.d);
    s4_nxt.bd   = pti_pkg::mul_split(s3_r.b, s3_r.d);
    s4_nxt.ae   = pti_pkg::mul_split(s3_r.a, s3_r.e);
  end

  // Stage 5: recombine the partial products.
  always_comb begin
    s5_nxt.dots = s4_r.dots;
    s5_nxt.ac   = pti_pkg::mul_join(s4_r.ac);
    s5_nxt.bb   = pti_pkg::mul_join(s4_r.bb);
    s5_nxt.be   = pti_pkg::mul_join(s4_r.be);
    s5_nxt.cd   = pti_pkg::mul_join(s4_r.cd);
    s5_nxt.bd   = pti_pkg::mul_join(s4_r.bd);
    s5_nxt.ae   = pti_pkg::mul_join(s4_r.ae);
  end

  // Stage 6: determinant, unnormalised parameters and edge-region terms.
  always_comb begin
    s6_nxt.geo    = s5_r.dots.geo;
    s6_nxt.det    = s5_r.ac - s5_r.bb;
    s6_nxt.sn     = s5_r.be - s5_r.cd;
    s6_nxt.tn     = s5_r.bd - s5_r.ae;
    s6_nxt.a      = pti_pkg::wide_t'(s5_r.dots.a);
    s6_nxt.c      = pti_pkg::wide_t'(s5_r.dots.c);
    s6_nxt.den    = pti_pkg::wide_t'(s5_r.dots.a) - (pti_pkg::wide_t'(s5_r.dots.b) <<< 1)
                  + pti_pkg::wide_t'(s5_r.dots.c);
    s6_nxt.m1_a   = pti_pkg::wide_t'(s5_r.dots.c) + pti_pkg::wide_t'(s5_r.dots.e);
    s6_nxt.m1_b   = pti_pkg::wide_t'(s5_r.dots.a) + pti_pkg::wide_t'(s5_r.dots.d);
    s6_nxt.diff_a = s6_nxt.m1_a
                  - (pti_pkg::wide_t'(s5_r.dots.b) + pti_pkg::wide_t'(s5_r.dots.d));
    s6_nxt.diff_b = s6_nxt.m1_b
                  - (pti_pkg::wide_t'(s5_r.dots.b) + pti_pkg::wide_t'(s5_r.dots.e));
    s6_nxt.negd   = -pti_pkg::wide_t'(s5_r.dots.d);
    s6_nxt.nege   = -pti_pkg::wide_t'(s5_r.dots.e);
    s6_nxt.dneg   = s5_r.dots.d[pti_pkg::DOT_W-1];
  end

  // Stage 7: sign and comparison flags for the region choice.
  always_comb begin
    le_sum            = s6_r.sn + s6_r.tn - s6_r.det;
    s7_nxt.geo        = s6_r.geo;
    s7_nxt.det        = s6_r.det;
    s7_nxt.sn         = s6_r.sn;
    s7_nxt.tn         = s6_r.tn;
    s7_nxt.den        = s6_r.den;
    s7_nxt.diff_a     = s6_r.diff_a;
    s7_nxt.diff_b     = s6_r.diff_b;
    s7_nxt.negd       = s6_r.negd;
    s7_nxt.nege       = s6_r.nege;
    s7_nxt.a          = s6_r.a;
    s7_nxt.c          = s6_r.c;
    s7_nxt.le         = le_sum[pti_pkg::WIDE_W-1] || (le_sum == '0);
    s7_nxt.sn_neg     = s6_r.sn[pti_pkg::WIDE_W-1];
    s7_nxt.tn_neg     = s6_r.tn[pti_pkg::WIDE_W-1];
    s7_nxt.dneg       = s6_r.dneg;
    s7_nxt.degen      = (s6_r.det == '0);
    s7_nxt.diff_a_pos = !s6_r.diff_a[pti_pkg::WIDE_W-1] && (s6_r.diff_a != '0);
    s7_nxt.diff_b_pos = !s6_r.diff_b[pti_pkg::WIDE_W-1] && (s6_r.diff_b != '0);
    s7_nxt.m1a_le0    = s6_r.m1_a[pti_pkg::WIDE_W-1] || (s6_r.m1_a == '0);
    s7_nxt.m1b_le0    = s6_r.m1_b[pti_pkg::WIDE_W-1] || (s6_r.m1_b == '0);
  end

  // Stage 8: pick the region, the divider operands and the parameter sources.
  // A negative or zero numerator divides to zero, which covers the edge
  // cases where the offset along an edge points away from it.
  always_comb begin
    s8_nxt.sb.geo   = s7_r.geo;
    s8_nxt.sb.degen = s7_r.degen;
    s8_nxt.sb.s_sel = pti_pkg::PSEL_ZERO;
    s8_nxt.sb.t_sel = pti_pkg::PSEL_ZERO;
    s8_nxt.num0     = '0;
    s8_nxt.den0     = '0;
    s8_nxt.num1     = '0;
    s8_nxt.den1     = '0;
    if (s7_r.le) begin
      if (s7_r.sn_neg) begin
        if (s7_r.tn_neg && s7_r.dneg) begin
          s8_nxt.num0     = s7_r.negd;
          s8_nxt.den0     = s7_r.a;
          s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
        end else begin
          s8_nxt.num1     = s7_r.nege;
          s8_nxt.den1     = s7_r.c;
          s8_nxt.sb.t_sel = pti_pkg::PSEL_QUOT;
        end
      end else if (s7_r.tn_neg) begin
        s8_nxt.num0     = s7_r.negd;
        s8_nxt.den0     = s7_r.a;
        s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
      end else begin
        s8_nxt.num0     = s7_r.sn;
        s8_nxt.den0     = s7_r.det;
        s8_nxt.num1     = s7_r.tn;
        s8_nxt.den1     = s7_r.det;
        s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
        s8_nxt.sb.t_sel = pti_pkg::PSEL_QUOT;
      end
    end else begin
      if (s7_r.sn_neg) begin
        if (s7_r.diff_a_pos) begin
          s8_nxt.num0     = s7_r.diff_a;
          s8_nxt.den0     = s7_r.den;
          s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
          s8_nxt.sb.t_sel = pti_pkg::PSEL_COMPL;
        end else if (s7_r.m1a_le0) begin
          s8_nxt.sb.t_sel = pti_pkg::PSEL_ONE;
        end else begin
          s8_nxt.num1     = s7_r.nege;
          s8_nxt.den1     = s7_r.c;
          s8_nxt.sb.t_sel = pti_pkg::PSEL_QUOT;
        end
      end else if (s7_r.tn_neg) begin
        if (s7_r.diff_b_pos) begin
          s8_nxt.num1     = s7_r.diff_b;
          s8_nxt.den1     = s7_r.den;
          s8_nxt.sb.t_sel = pti_pkg::PSEL_QUOT;
          s8_nxt.sb.s_sel = pti_pkg::PSEL_COMPL;
        end else if (s7_r.m1b_le0) begin
          s8_nxt.sb.s_sel = pti_pkg::PSEL_ONE;
        end else begin
          s8_nxt.num0     = s7_r.negd;
          s8_nxt.den0     = s7_r.a;
          s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
        end
      end else begin
        s8_nxt.num0     = s7_r.diff_a;
        s8_nxt.den0     = s7_r.den;
        s8_nxt.sb.s_sel = pti_pkg::PSEL_QUOT;
        s8_nxt.sb.t_sel = pti_pkg::PSEL_COMPL;
      end
    end
  end

  // Stage registers all advance together.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
      s8_r <= s8_nxt;
    end
  end

endmodule

>>> src/pti_div.sv
`timescale 1ns / 1ps

module pti_div (
  input  logic            clk,
  input  logic            en,
  input  pti_pkg::wide_t  num,
  input  pti_pkg::wide_t  den,
  output pti_pkg::param_t quot
);

  localparam int N = pti_pkg::DIV_STEPS;
  localparam int W = pti_pkg::WIDE_W;

  logic [W-1:0]                  rem_r  [N+1];
  logic [W-1:0]                  den_r  [N+1];
  logic [pti_pkg::FRAC_W-1:0]    q_r    [N+1];
  logic                          zero_r [N+1];
  logic                          one_r  [N+1];
  pti_pkg::wide_t                pre_diff;
  logic                          pre_zero;
  logic                          pre_one;

  // Clamp check: a non-positive numerator gives zero, one at or above the
  // divisor gives one, and only the remaining case is divided.
  always_comb begin
    pre_diff = num - den;
    pre_zero = num[W-1] || (num == '0);
    pre_one  = !pre_zero && !pre_diff[W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      zero_r[0] <= pre_zero;
      one_r[0]  <= pre_one;
    end
  end

  // One restoring step per stage, one quotient bit each.
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0] rem2;
    logic [W-1:0] sub;
    logic         ge;

    always_comb begin
      rem2 = {rem_r[k][W-2:0], 1'b0};
      sub  = rem2 - den_r[k];
      ge   = (rem2 >= den_r[k]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? sub : rem2;
        den_r[k+1]  <= den_r[k];
        q_r[k+1]    <= {q_r[k][pti_pkg::FRAC_W-2:0], ge};
        zero_r[k+1] <= zero_r[k];
        one_r[k+1]  <= one_r[k];
      end
    end
  end

  always_comb begin
    if (zero_r[N]) begin
      quot = '0;
    end else if (one_r[N]) begin
      quot = pti_pkg::PARAM_ONE;
    end else begin
      quot = {1'b0, q_r[N]};
    end
  end

endmodule

>>> src/pti_back.sv
`timescale 1ns / 1ps

module pti_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        pop,
  input  pti_pkg::qitem_t             pop_data,
  input  logic [pti_pkg::DIST_W-1:0]  limit_sq,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pti_pkg::out_item_t          out_data
);

  localparam int N = pti_pkg::DIV_STEPS;

  typedef struct packed {
    pti_pkg::geo_t   geo;
    pti_pkg::param_t s;
    pti_pkg::param_t t;
    logic            degen;
  } c1_t;

  typedef struct packed {
    pti_pkg::coord_t  [2:0] p;
    pti_pkg::coord_t  [2:0] v0;
    pti_pkg::mprod_t  [2:0] ms;
    pti_pkg::mprod_t  [2:0] mt;
    pti_pkg::param_t        s;
    pti_pkg::param_t        t;
    logic                   degen;
  } c2_t;

  typedef struct packed {
    pti_pkg::coord_t [2:0] p;
    pti_pkg::coord_t [2:0] cl;
    pti_pkg::param_t       s;
    pti_pkg::param_t       t;
    logic                  degen;
  } c3_t;

  typedef struct packed {
    logic [2:0][pti_pkg::PROD_W-1:0] sq;
    pti_pkg::coord_t [2:0]           cl;
    pti_pkg::param_t                 s;
    pti_pkg::param_t                 t;
    logic                            degen;
  } c4_t;

  logic                       en;
  logic [N:0]                 bv_r;
  logic [3:0]                 cv_r;
  logic                       out_valid_r;
  pti_pkg::sb_t               sb_r [N+1];
  pti_pkg::param_t            q0;
  pti_pkg::param_t            q1;
  c1_t                        c1_r, c1_nxt;
  c2_t                        c2_r, c2_nxt;
  c3_t                        c3_r, c3_nxt;
  c4_t                        c4_r, c4_nxt;
  pti_pkg::out_item_t         out_r, out_nxt;
  pti_pkg::acc_t              acc [3];
  logic [pti_pkg::DSUM_W-1:0] dsum;
  logic [pti_pkg::DIST_W-1:0] dsq;
  pti_pkg::edge_t             df [3];

  // The whole back half stalls only when its output register is held.
  assign en        = !out_valid_r || out_ready;
  assign pop       = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[N-1:0], pop};
      cv_r        <= {cv_r[2:0], bv_r[N]};
      out_valid_r <= cv_r[3];
    end
  end

  // Two dividers, one per edge parameter.
  pti_div u_div0 (
    .clk  (clk),
    .en   (en),
    .num  (pop_data.num0),
    .den  (pop_data.den0),
    .quot (q0)
  );

  pti_div u_div1 (
    .clk  (clk),
    .en   (en),
    .num  (pop_data.num1),
    .den  (pop_data.den1),
    .quot (q1)
  );

  // Side information kept in step with the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= pop_data.sb;
      for (int k = 0; k < N; k++) begin
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  // Compose the edge parameters s and t.
  always_comb begin
    c1_nxt.geo   = sb_r[N].geo;
    c1_nxt.degen = sb_r[N].degen;
    case (sb_r[N].s_sel)
      pti_pkg::PSEL_ZERO:  c1_nxt.s = '0;
      pti_pkg::PSEL_ONE:   c1_nxt.s = pti_pkg::PARAM_ONE;
      pti_pkg::PSEL_QUOT:  c1_nxt.s = q0;
      pti_pkg::PSEL_COMPL: c1_nxt.s = pti_pkg::PARAM_ONE - q1;
      default:             c1_nxt.s = '0;
    endcase
    case (sb_r[N].t_sel)
      pti_pkg::PSEL_ZERO:  c1_nxt.t = '0;
      pti_pkg::PSEL_ONE:   c1_nxt.t = pti_pkg::PARAM_ONE;
      pti_pkg::PSEL_QUOT:  c1_nxt.t = q1;
      pti_pkg::PSEL_COMPL: c1_nxt.t = pti_pkg::PARAM_ONE - q0;
      default:             c1_nxt.t = '0;
    endcase
  end

  // Scale each edge by its parameter.
  always_comb begin
    c2_nxt.p     = c1_r.geo.p;
    c2_nxt.v0    = c1_r.geo.v0;
    c2_nxt.s     = c1_r.s;
    c2_nxt.t     = c1_r.t;
    c2_nxt.degen = c1_r.degen;
    for (int i = 0; i < 3; i++) begin
      c2_nxt.ms[i] = $signed(c1_r.geo.e0[i]) * $signed({1'b0, c1_r.s});
      c2_nxt.mt[i] = $signed(c1_r.geo.e1[i]) * $signed({1'b0, c1_r.t});
    end
  end

  // Closest point, rounded toward minus infinity by the arithmetic shift.
  always_comb begin
    c3_nxt.p     = c2_r.p;
    c3_nxt.s     = c2_r.s;
    c3_nxt.t     = c2_r.t;
    c3_nxt.degen = c2_r.degen;
    for (int i = 0; i < 3; i++) begin
      acc[i] = (pti_pkg::acc_t'($signed(c2_r.v0[i])) <<< pti_pkg::FRAC_W)
             + pti_pkg::acc_t'($signed(c2_r.ms[i]))
             + pti_pkg::acc_t'($signed(c2_r.mt[i]));
      c3_nxt.cl[i] = acc[i][pti_pkg::FRAC_W +: pti_pkg::COORD_W];
    end
  end

  // Squared offsets from the query point.
  always_comb begin
    c4_nxt.cl    = c3_r.cl;
    c4_nxt.s     = c3_r.s;
    c4_nxt.t     = c3_r.t;
    c4_nxt.degen = c3_r.degen;
    for (int i = 0; i < 3; i++) begin
      df[i]        = pti_pkg::edge_t'($signed(c3_r.cl[i]))
                   - pti_pkg::edge_t'($signed(c3_r.p[i]));
      c4_nxt.sq[i] = df[i] * df[i];
    end
  end

  // Distance, saturation, limit compare and the degenerate override.
  always_comb begin
    dsum = pti_pkg::DSUM_W'(c4_r.sq[0]) + pti_pkg::DSUM_W'(c4_r.sq[1])
         + pti_pkg::DSUM_W'(c4_r.sq[2]);
    if (|dsum[pti_pkg::DSUM_W-1:pti_pkg::DIST_W]) begin
      dsq = '1;
    end else begin
      dsq = dsum[pti_pkg::DIST_W-1:0];
    end
    if (c4_r.degen) begin
      out_nxt            = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.found       = (dsq <= limit_sq);
      out_nxt.degenerate  = 1'b0;
      out_nxt.edge0_param = c4_r.s;
      out_nxt.edge1_param = c4_r.t;
      out_nxt.closest_x   = c4_r.cl[0];
      out_nxt.closest_y   = c4_r.cl[1];
      out_nxt.closest_z   = c4_r.cl[2];
      out_nxt.distance_sq = dsq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c1_nxt;
      c2_r  <= c2_nxt;
      c3_r  <= c3_nxt;
      c4_r  <= c4_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

>>> src/point_triangle_closest_point_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     pti_pkg::in_item_t (query and vertices)
// out_      output     out_valid / out_ready   pti_pkg::out_item_t (closest point, distance)
// cfg_      input      cfg_we                  cfg_wdata, squared distance limit
//
// One request is taken per cycle while in_ready is high. Most of the pipeline is the
// two 16-stage restoring dividers that form the edge parameters.
// Reset is synchronous on rst_n low; the limit register returns to all ones.
// The front stalls only when the four-entry queue is full; the back stalls
// only while its output register waits for out_ready.

module point_triangle_closest_point_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pti_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pti_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [pti_pkg::DIST_W-1:0]  cfg_wdata
);

  logic [pti_pkg::DIST_W-1:0] max_dist_r;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  pti_pkg::qitem_t            q_wdata;
  pti_pkg::qitem_t            q_rdata;

  // Distance limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= '1;
    end else if (cfg_we) begin
      max_dist_r <= cfg_wdata;
    end
  end

  pti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_wdata)
  );

  pti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  pti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .limit_sq  (max_dist_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
